FILE: hdl/ntc_pkg.sv
`default_nettype none

package ntc_pkg;

    // Rows held in the constant table
    localparam int STORED_ROWS = 19;
    localparam int IDX_W       = 5;
    localparam int RES_W       = 13;
    localparam int OHM_W       = 12;
    localparam int DEG_W       = 7;
    localparam int TEMP_W      = 10;
    localparam int FRAC_W      = 4;

    // Full-scale constants of the resistance formula
    localparam int ADC_W      = 12;
    localparam int REF_R      = 15000;
    localparam int REF_COUNT  = 5000;
    localparam int RES_NUM_W  = 26;
    localparam int RES_DEN_W  = 16;

    // Interpolation steps per table row
    localparam int FRAC_FULL  = 10;
    localparam int FRAC_NUM_W = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OHM_W-1:0] ohm_t;
    typedef logic [RES_W-1:0] res_t;

    // Table temperature of a row: 5 degrees per row, first row at 5
    function automatic logic [DEG_W-1:0] row_deg(input idx_t idx);
        logic [DEG_W-1:0] base;
        base = DEG_W'(idx) + DEG_W'(1);
        return DEG_W'(base * DEG_W'(5));
    endfunction

    // Table resistance of a row for the selected sensor column
    function automatic ohm_t row_ohms(input idx_t idx, input logic col);
        ohm_t val;
        val = '0;
        unique case (idx)
            5'd0:  val = col ? 12'd2592 : 12'd2265;
            5'd1:  val = col ? 12'd2017 : 12'd1830;
            5'd2:  val = col ? 12'd1583 : 12'd1487;
            5'd3:  val = col ? 12'd1253 : 12'd1216;
            5'd4:  val = col ? 12'd1000 : 12'd1000;
            5'd5:  val = col ? 12'd803  : 12'd827;
            5'd6:  val = col ? 12'd650  : 12'd687;
            5'd7:  val = col ? 12'd530  : 12'd574;
            5'd8:  val = col ? 12'd434  : 12'd481;
            5'd9:  val = col ? 12'd358  : 12'd406;
            5'd10: val = col ? 12'd297  : 12'd344;
            5'd11: val = col ? 12'd248  : 12'd293;
            5'd12: val = col ? 12'd208  : 12'd250;
            5'd13: val = col ? 12'd176  : 12'd215;
            5'd14: val = col ? 12'd149  : 12'd185;
            5'd15: val = col ? 12'd127  : 12'd160;
            5'd16: val = col ? 12'd108  : 12'd139;
            5'd17: val = col ? 12'd93   : 12'd121;
            5'd18: val = col ? 12'd80   : 12'd106;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ntc_table_temperature_convert_top.sv
`default_nettype none

// Channel  Dir  Width  Contents
// s_*      in   16+1   tdata: adc_sample; tuser: sensor_sel
// m_*      out  24+1   tdata: resistance, temp_tenths; tuser: out_of_table
//
// One sample per cycle while the output is not stalled. Samples pass through the
// 13-stage resistance divider, the search stages, the 4-stage fraction divider
// and the output register. The whole pipeline advances together and holds while a
// result waits on m_tready; s_tready follows that hold. Reset clears valid bits.
module ntc_table_temperature_convert_top #(
    parameter int TABLE_ROWS = 19
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] adc_sample
    input  wire logic        s_tuser,   // [0] sensor_sel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [12:0] resistance, [22:13] temp_tenths, [23] zero
    output logic             m_tuser    // [0] out_of_table
);
    import ntc_pkg::*;

    localparam int ROWS = (TABLE_ROWS > STORED_ROWS) ? STORED_ROWS :
                          (TABLE_ROWS < 2) ? 2 : TABLE_ROWS;
    localparam int SIDE2_W = RES_W + IDX_W + 2;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Resistance = 15000*a / (10*(5000-a)); both truncations fold into one
    logic [ADC_W-1:0]     adc;
    logic [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0] res_den;

    assign adc     = s_tdata[15:4];
    assign res_num = RES_NUM_W'(adc) * RES_NUM_W'(REF_R);
    assign res_den = RES_DEN_W'(RES_DEN_W'(REF_COUNT) - RES_DEN_W'(adc)) * RES_DEN_W'(10);

    logic d1_valid;
    res_t d1_res;
    logic d1_col;

    ntc_div #(
        .NUM_W  (RES_NUM_W),
        .DEN_W  (RES_DEN_W),
        .Q_W    (RES_W),
        .SIDE_W (1)
    ) u_res_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .num       (res_num),
        .den       (res_den),
        .side_in   (s_tuser),
        .out_valid (d1_valid),
        .quot      (d1_res),
        .side_out  (d1_col)
    );

    logic sr_valid;
    idx_t sr_lo;
    res_t sr_res;
    logic sr_col;

    ntc_search #(
        .ROWS (ROWS)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .res_in    (d1_res),
        .col_in    (d1_col),
        .out_valid (sr_valid),
        .lo        (sr_lo),
        .res_out   (sr_res),
        .col_out   (sr_col)
    );

    // Bracket check and fraction operands
    idx_t                  sr_hi;
    res_t                  r_left;
    res_t                  r_right;
    logic                  above;
    logic                  beyond;
    logic [FRAC_NUM_W-1:0] frac_num;
    logic [OHM_W-1:0]      frac_den;

    assign sr_hi    = sr_lo + IDX_W'(1);
    assign r_left   = RES_W'(row_ohms(sr_lo, sr_col));
    assign r_right  = RES_W'(row_ohms(sr_hi, sr_col));
    assign above    = sr_res > r_left;
    assign beyond   = sr_res < r_right;
    assign frac_num = (above || beyond) ? '0 :
                      FRAC_NUM_W'(r_left - sr_res) * FRAC_NUM_W'(FRAC_FULL);
    assign frac_den = OHM_W'(r_left - r_right);

    logic               d2_valid;
    logic [FRAC_W-1:0]  d2_frac;
    logic [SIDE2_W-1:0] d2_side;
    res_t               o_res;
    idx_t               o_lo;
    logic               o_flag;
    logic               o_beyond;

    ntc_div #(
        .NUM_W  (FRAC_NUM_W),
        .DEN_W  (OHM_W),
        .Q_W    (FRAC_W),
        .SIDE_W (SIDE2_W)
    ) u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sr_valid),
        .num       (frac_num),
        .den       (frac_den),
        .side_in   ({beyond, above || beyond, sr_lo, sr_res}),
        .out_valid (d2_valid),
        .quot      (d2_frac),
        .side_out  (d2_side)
    );

    assign {o_beyond, o_flag, o_lo, o_res} = d2_side;

    // Clamp the fraction and blend the two row temperatures
    logic [FRAC_W-1:0] frac;
    logic [TEMP_W-1:0] temp;

    assign frac = o_beyond ? FRAC_W'(FRAC_FULL) : (o_flag ? '0 : d2_frac);
    assign temp = TEMP_W'(row_deg(o_lo + IDX_W'(1))) * TEMP_W'(frac) +
                  TEMP_W'(row_deg(o_lo)) * TEMP_W'(FRAC_W'(FRAC_FULL) - frac);

    // Output register
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic [TEMP_W-1:0] out_temp_reg;
    logic              out_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg  <= o_res;
            out_temp_reg <= temp;
            out_flag_reg <= o_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_temp_reg, out_res_reg};
    assign m_tuser  = out_flag_reg;

    // Checks
    a_flag_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[22:13] == 10'd50 || m_tdata[22:13] == 10'd950))
        else $error("flagged result not at a table end");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:13] >= 10'd50 && m_tdata[22:13] <= 10'd950))
        else $error("temperature out of table range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

FILE: hdl/ntc_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees the quotient fits in Q_W bits.
module ntc_div #(
    parameter int NUM_W  = 26,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 13,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quot,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              valid_reg [Q_W+1];
    logic [CW-1:0]     rem_reg   [Q_W+1];
    logic [DEN_W-1:0]  den_reg   [Q_W+1];
    logic [Q_W-1:0]    quot_reg  [Q_W+1];
    logic [SIDE_W-1:0] side_reg  [Q_W+1];

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= CW'(num);
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    // One trial subtraction per stage, most significant bit first
    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        localparam int BIT = Q_W - 1 - i;
        logic [CW-1:0]  trial;
        logic           fits;
        logic [Q_W-1:0] qbit;

        assign trial = CW'(den_reg[i]) << BIT;
        assign fits  = (rem_reg[i] >= trial);
        assign qbit  = Q_W'(fits) << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= fits ? rem_reg[i] - trial : rem_reg[i];
                den_reg[i+1]  <= den_reg[i];
                quot_reg[i+1] <= quot_reg[i] | qbit;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quot      = quot_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

`default_nettype wire

FILE: hdl/ntc_search.sv
`default_nettype none

// Pipelined binary search for the bracketing rows of a descending table.
module ntc_search #(
    parameter int ROWS = 19
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire ntc_pkg::res_t res_in,
    input  wire logic          col_in,
    output logic               out_valid,
    output ntc_pkg::idx_t      lo,
    output ntc_pkg::res_t      res_out,
    output logic               col_out
);
    import ntc_pkg::*;

    localparam int STEPS = (ROWS <= 2) ? 1 : $clog2(ROWS - 1);

    logic  valid_reg [STEPS+1];
    idx_t  lo_reg    [STEPS+1];
    idx_t  hi_reg    [STEPS+1];
    res_t  res_reg   [STEPS+1];
    logic  col_reg   [STEPS+1];

    // Load the full row span
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg[0]  <= '0;
            hi_reg[0]  <= IDX_W'(ROWS - 1);
            res_reg[0] <= res_in;
            col_reg[0] <= col_in;
        end
    end

    // Halve the span once per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [IDX_W:0] sum;
        idx_t           mid;
        logic           open;
        logic           below;

        assign sum   = (IDX_W+1)'(lo_reg[i]) + (IDX_W+1)'(hi_reg[i]) + (IDX_W+1)'(1);
        assign mid   = sum[IDX_W:1];
        assign open  = (hi_reg[i] - lo_reg[i]) > IDX_W'(1);
        assign below = (RES_W'(row_ohms(mid, col_reg[i])) < res_reg[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[i+1]  <= (open && !below) ? mid : lo_reg[i];
                hi_reg[i+1]  <= (open && below) ? mid : hi_reg[i];
                res_reg[i+1] <= res_reg[i];
                col_reg[i+1] <= col_reg[i];
            end
        end
    end

    // Search ends with hi one above lo
    assign out_valid = valid_reg[STEPS];
    assign lo        = lo_reg[STEPS];
    assign res_out   = res_reg[STEPS];
    assign col_out   = col_reg[STEPS];

endmodule

`default_nettype wire
